// File: rtl/core/zvct_pkg.sv
// Shared types and constants for the zoom view center tracker.
// Fixed-point formats, config register indexes, and controller/datapath command and status.
// No dependencies; compile first.
package zvct_pkg;

  // Fixed-point fraction bits for centers, zoom, gain and deadzone
  localparam int FRAC = 8;

  // Field widths
  localparam int SCREEN_W = 13;
  localparam int SENS_W   = 12;
  localparam int DZ_W     = 9;
  localparam int ZOOM_W   = 16;
  localparam int DELTA_W  = 16;
  localparam int CENTER_W = SCREEN_W + FRAC;
  localparam int CNT_W    = 8;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Deadzone half-band divide: num = screen*dz << FRAC, den = 2*zoom.
  // With zoom above 1.0 the divisor exceeds 2^(FRAC+1), so the quotient
  // fits in NUM_W-FRAC-1 bits and the top FRAC+1 bits seed the remainder.
  localparam int DZ_PROD_W = SCREEN_W + DZ_W;
  localparam int NUM_W     = DZ_PROD_W + FRAC;
  localparam int DEN_W     = ZOOM_W + 1;
  localparam int QUOT_W    = NUM_W - FRAC - 1;
  localparam int DIV_CNT_W = $clog2(QUOT_W);

  // Pan product and signed working width for center arithmetic
  localparam int PAN_W  = DELTA_W + SENS_W + 1;
  localparam int WORK_W = PAN_W + 1;

  // Lock engages after this many frozen ticks with raw movement
  localparam logic [CNT_W-1:0] LOCK_TICKS = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  localparam logic [ZOOM_W-1:0] ZOOM_ONE = ZOOM_W'(1 << FRAC);

  // Reset values of the config registers
  localparam logic [SCREEN_W-1:0] SCREEN_W_RST = SCREEN_W'(1920);
  localparam logic [SCREEN_W-1:0] SCREEN_H_RST = SCREEN_W'(1080);
  localparam logic [SENS_W-1:0]   SENS_RST     = SENS_W'(256);
  localparam logic [DZ_W-1:0]     DZ_RST       = DZ_W'(0);

  // Operation codes
  localparam logic FUNC_UPDATE   = 1'b0;
  localparam logic FUNC_RECENTER = 1'b1;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_PAN_SENS      = 2'd2,
    CFG_DEADZONE      = 2'd3
  } cfg_index_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted transaction
    logic prep;      // register the products
    logic div_load;  // seed the dividers
    logic div_step;  // one quotient bit per lane
    logic commit;    // update state and load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_needed;  // update with active deadzone band
    logic out_free;    // result register can take a new transaction
  } dp_status_t;

endpackage

// File: rtl/core/zvct_if.sv
// Valid/ready channel interfaces for the zoom view center tracker.
// Depends on zvct_pkg for field widths.
interface zvct_item_if;
  import zvct_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [SCREEN_W-1:0]       cursor_x;
  logic [SCREEN_W-1:0]       cursor_y;
  logic signed [DELTA_W-1:0] raw_dx;
  logic signed [DELTA_W-1:0] raw_dy;
  logic [ZOOM_W-1:0]         zoom_level;

  modport source (output valid, func, cursor_x, cursor_y, raw_dx, raw_dy, zoom_level,
                  input ready);
  modport sink (input valid, func, cursor_x, cursor_y, raw_dx, raw_dy, zoom_level,
                output ready);
endinterface

interface zvct_result_if;
  import zvct_pkg::*;
  logic                valid;
  logic                ready;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic                lock_active;

  modport source (output valid, center_x, center_y, lock_active, input ready);
  modport sink (input valid, center_x, center_y, lock_active, output ready);
endinterface

// File: rtl/core/zvct_div.sv
// Restoring divider lane, one quotient bit per step, for the deadzone half-band.
// Depends on zvct_pkg for the numerator, divisor and quotient widths.
module zvct_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [zvct_pkg::NUM_W-1:0]    num,
  input  logic [zvct_pkg::DEN_W-1:0]    den,
  output logic [zvct_pkg::QUOT_W-1:0]   quot
);
  import zvct_pkg::*;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  divisor;
  logic [QUOT_W-1:0] shift;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Shift in the next numerator bit and try to subtract
  assign trial = {rem, shift[QUOT_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (load) begin
      rem     <= DEN_W'(num[NUM_W-1:QUOT_W]);
      shift   <= num[QUOT_W-1:0];
      divisor <= den;
    end else if (step) begin
      rem   <= fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
      shift <= {shift[QUOT_W-2:0], fits};
    end
  end

  assign quot = shift;

endmodule

// File: rtl/core/zvct_ctrl.sv
// Sequencing controller: accept, product, divide and commit steps.
// Depends on zvct_pkg for command/status structs and divider length.
module zvct_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  zvct_pkg::dp_status_t status,
  output zvct_pkg::dp_cmd_t    cmd
);
  import zvct_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_DLOAD  = 5'b00100,
    S_DIV    = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;

  assign div_last = div_cnt == DIV_CNT_W'(QUOT_W - 1);

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    item_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.div_needed ? S_DLOAD : S_UPDATE;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_last) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      // Count divider steps
      if (state == S_DLOAD)     div_cnt <= '0;
      else if (state == S_DIV)  div_cnt <= div_cnt + 1'b1;
    end
  end

endmodule

// File: rtl/core/zvct_dpath.sv
// Datapath: config registers, tracker state, products, divider lanes,
// center update with clamp, and the result register.
// Depends on zvct_pkg and zvct_div.
module zvct_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [zvct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zvct_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              func,
  input  logic [zvct_pkg::SCREEN_W-1:0]     cursor_x,
  input  logic [zvct_pkg::SCREEN_W-1:0]     cursor_y,
  input  logic signed [zvct_pkg::DELTA_W-1:0] raw_dx,
  input  logic signed [zvct_pkg::DELTA_W-1:0] raw_dy,
  input  logic [zvct_pkg::ZOOM_W-1:0]       zoom_level,
  input  zvct_pkg::dp_cmd_t                 cmd,
  output zvct_pkg::dp_status_t              status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [zvct_pkg::CENTER_W-1:0]     center_x,
  output logic [zvct_pkg::CENTER_W-1:0]     center_y,
  output logic                              lock_active
);
  import zvct_pkg::*;

  // Config registers
  logic [SCREEN_W-1:0] scr_w;
  logic [SCREEN_W-1:0] scr_h;
  logic [SENS_W-1:0]   sens;
  logic [DZ_W-1:0]     dz;

  // Tracker state
  logic [CENTER_W-1:0] view_x;
  logic [CENTER_W-1:0] view_y;
  logic [SCREEN_W-1:0] prev_x;
  logic [SCREEN_W-1:0] prev_y;
  logic                seen;
  logic                lock;
  logic [CNT_W-1:0]    run_cnt;

  // Captured transaction
  logic                      op;
  logic [SCREEN_W-1:0]       cx;
  logic [SCREEN_W-1:0]       cy;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic [ZOOM_W-1:0]         zoom;

  // Registered products
  logic [DZ_PROD_W-1:0]    dzp_x;
  logic [DZ_PROD_W-1:0]    dzp_y;
  logic signed [PAN_W-1:0] pan_x;
  logic signed [PAN_W-1:0] pan_y;

  logic [QUOT_W-1:0] hd_x;
  logic [QUOT_W-1:0] hd_y;

  logic             moved;
  logic             raw;
  logic             dz_mode;
  logic             lock_next;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] cnt_inc;
  logic [CENTER_W-1:0] new_x;
  logic [CENTER_W-1:0] new_y;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w <= SCREEN_W_RST;
      scr_h <= SCREEN_H_RST;
      sens  <= SENS_RST;
      dz    <= DZ_RST;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_SCREEN_WIDTH:  scr_w <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: scr_h <= cfg_data[SCREEN_W-1:0];
        CFG_PAN_SENS:      sens  <= cfg_data[SENS_W-1:0];
        CFG_DEADZONE:      dz    <= cfg_data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction and form the products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= func;
      cx   <= cursor_x;
      cy   <= cursor_y;
      dx   <= raw_dx;
      dy   <= raw_dy;
      zoom <= zoom_level;
    end
    if (cmd.prep) begin
      dzp_x <= DZ_PROD_W'(scr_w) * DZ_PROD_W'(dz);
      dzp_y <= DZ_PROD_W'(scr_h) * DZ_PROD_W'(dz);
      pan_x <= PAN_W'(dx) * PAN_W'($signed({1'b0, sens}));
      pan_y <= PAN_W'(dy) * PAN_W'($signed({1'b0, sens}));
    end
  end

  // Deadzone half-band lanes
  zvct_div u_div_x (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .num  ({dzp_x, {FRAC{1'b0}}}),
    .den  ({zoom, 1'b0}),
    .quot (hd_x)
  );

  zvct_div u_div_y (
    .clk  (clk),
    .load (cmd.div_load),
    .step (cmd.div_step),
    .num  ({dzp_y, {FRAC{1'b0}}}),
    .den  ({zoom, 1'b0}),
    .quot (hd_y)
  );

  // Decode the update case
  assign moved   = !seen || (cx != prev_x) || (cy != prev_y);
  assign raw     = (dx != '0) || (dy != '0);
  assign dz_mode = (zoom > ZOOM_ONE) && (dz != '0);
  assign cnt_inc = (run_cnt != CNT_MAX) ? run_cnt + 1'b1 : run_cnt;

  assign status.div_needed = (op == FUNC_UPDATE) && moved && dz_mode;
  assign status.out_free   = !out_valid || out_ready;

  // Lock and frozen-run counter
  always_comb begin
    lock_next = lock;
    cnt_next  = run_cnt;
    if (moved) begin
      lock_next = 1'b0;
      cnt_next  = '0;
    end else if (raw) begin
      if (!lock) begin
        cnt_next  = cnt_inc;
        lock_next = cnt_inc >= LOCK_TICKS;
      end
    end else begin
      cnt_next = '0;
    end
  end

  // Per-axis center update followed by the clamp to [0, screen]
  function automatic logic [CENTER_W-1:0] axis_update(
    input logic [CENTER_W-1:0]    c,
    input logic [SCREEN_W-1:0]    cur,
    input logic [SCREEN_W-1:0]    scr,
    input logic [QUOT_W-1:0]      hd,
    input logic signed [PAN_W-1:0] pan,
    input logic                   mv,
    input logic                   rw,
    input logic                   dzm,
    input logic                   lk
  );
    logic signed [WORK_W-1:0] cw;
    logic signed [WORK_W-1:0] cq;
    logic signed [WORK_W-1:0] hw;
    logic signed [WORK_W-1:0] hi;
    logic signed [WORK_W-1:0] v;
    cw = $signed(WORK_W'(c));
    cq = $signed(WORK_W'({cur, {FRAC{1'b0}}}));
    hw = $signed(WORK_W'(hd));
    hi = $signed(WORK_W'({scr, {FRAC{1'b0}}}));
    v  = cw;
    if (mv) begin
      if (dzm) begin
        if (cq - cw > hw)      v = cq - hw;
        else if (cw - cq > hw) v = cq + hw;
      end else begin
        v = cq;
      end
    end else if (rw && lk) begin
      v = cw + WORK_W'(pan);
    end
    if (v < 0)       axis_update = '0;
    else if (v > hi) axis_update = hi[CENTER_W-1:0];
    else             axis_update = v[CENTER_W-1:0];
  endfunction

  always_comb begin
    if (op == FUNC_RECENTER) begin
      new_x = CENTER_W'({scr_w, {(FRAC-1){1'b0}}});
      new_y = CENTER_W'({scr_h, {(FRAC-1){1'b0}}});
    end else begin
      new_x = axis_update(view_x, cx, scr_w, hd_x, pan_x, moved, raw, dz_mode, lock_next);
      new_y = axis_update(view_y, cy, scr_h, hd_y, pan_y, moved, raw, dz_mode, lock_next);
    end
  end

  // Commit state; recenter leaves lock, counter and previous cursor alone
  always_ff @(posedge clk) begin
    if (rst) begin
      view_x  <= CENTER_W'({SCREEN_W_RST, {(FRAC-1){1'b0}}});
      view_y  <= CENTER_W'({SCREEN_H_RST, {(FRAC-1){1'b0}}});
      prev_x  <= '0;
      prev_y  <= '0;
      seen    <= 1'b0;
      lock    <= 1'b0;
      run_cnt <= '0;
    end else if (cmd.commit) begin
      view_x <= new_x;
      view_y <= new_y;
      if (op == FUNC_UPDATE) begin
        prev_x  <= cx;
        prev_y  <= cy;
        seen    <= 1'b1;
        lock    <= lock_next;
        run_cnt <= cnt_next;
      end
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      center_x    <= new_x;
      center_y    <= new_y;
      lock_active <= (op == FUNC_UPDATE) ? lock_next : lock;
    end
  end

endmodule

// File: rtl/core/zoom_view_center_tracker_top.sv
// Zoom view center tracker: item and result channels, config write port.
// Input transaction: func (0 update, 1 recenter), cursor_x/y, raw_dx/dy, zoom_level.
// Result transaction: center_x/y (pixels, 8 fraction bits) and lock_active.
// Exactly one result per accepted item, in order.
// Each item passes through the capture, product and update steps; when an update
// moves the cursor with zoom above 1.0 and a nonzero deadzone, a divider load and
// the 21-step restoring divide that forms the deadzone half-band come between,
// one quotient bit per cycle, both axes in parallel.
// One item is in work at a time.
// The result register is separate from the work: a new item is accepted while a
// result still waits. If the receiver stalls, the next result waits in the
// update step until the register frees, and input is held off meanwhile.
// Config writes (cfg_write, cfg_index, cfg_data) take effect at once; the user must
// make them only while the block is idle, which the block itself does not enforce.
// Reset (rst, synchronous): config returns to 1920, 1080, 256, 0; the center to
// the screen middle; lock, run counter and cursor history clear.
// Depends on zvct_pkg, zvct_if, zvct_div, zvct_ctrl, zvct_dpath.
module zoom_view_center_tracker_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [zvct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zvct_pkg::CFG_W-1:0]     cfg_data,
  zvct_item_if.sink                      item,
  zvct_result_if.source                  result
);
  import zvct_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  zvct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  zvct_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (item.func),
    .cursor_x    (item.cursor_x),
    .cursor_y    (item.cursor_y),
    .raw_dx      (item.raw_dx),
    .raw_dy      (item.raw_dy),
    .zoom_level  (item.zoom_level),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .center_x    (result.center_x),
    .center_y    (result.center_y),
    .lock_active (result.lock_active)
  );

endmodule

// File: sim/tb_zoom_view_center_tracker_top.sv
// Self-checking testbench for zoom_view_center_tracker_top: a directed table, then random
// frames over several register settings, each result checked by table or tracker model.
// Depends on zvct_pkg, zvct_if and the tracker RTL.
`timescale 1ns / 1ps

module tb_zoom_view_center_tracker_top;
  import zvct_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 200;
  localparam int TIMEOUT_NS   = 1_000_000;

  typedef struct packed {
    logic                func;
    logic [SCREEN_W-1:0] cx;
    logic [SCREEN_W-1:0] cy;
    logic [DELTA_W-1:0]  dx;
    logic [DELTA_W-1:0]  dy;
    logic [ZOOM_W-1:0]   zoom;
  } frame_t;

  typedef struct packed {
    logic [CENTER_W-1:0] x;
    logic [CENTER_W-1:0] y;
    logic                lock;
  } center_t;

  typedef struct {
    bit               is_reg;
    cfg_index_t       idx;
    logic [CFG_W-1:0] val;
    frame_t           f;
    bit               typed;
    center_t          want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  cfg_index_t       cfg_index = CFG_SCREEN_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  zvct_item_if   item_if();
  zvct_result_if result_if();

  zoom_view_center_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  always #1 clk = ~clk;

  // Tracker model: register copies and view state
  logic [SCREEN_W-1:0] scr_w = SCREEN_W_RST;
  logic [SCREEN_W-1:0] scr_h = SCREEN_H_RST;
  logic [SENS_W-1:0]   gain = SENS_RST;
  logic [DZ_W-1:0]     dz_frac = DZ_RST;
  longint              ctr_x = longint'(SCREEN_W_RST) << (FRAC - 1);
  longint              ctr_y = longint'(SCREEN_H_RST) << (FRAC - 1);
  logic [SCREEN_W-1:0] last_cx = '0;
  logic [SCREEN_W-1:0] last_cy = '0;
  logic                seen = 1'b0;
  logic                locked = 1'b0;
  logic [CNT_W-1:0]    frozen_ticks = '0;

  center_t center_q[$];
  int      error_count = 0;
  int      burst_left = 0;
  int      gap_max = 6;
  int      run_left = 0;
  bit      hold_req = 1'b0;

  // Follow the cursor only when it leaves the deadzone band
  function automatic longint band_follow(input longint ctr, input logic [SCREEN_W-1:0] cur,
                                         input logic [SCREEN_W-1:0] scr,
                                         input logic [ZOOM_W-1:0] zoom);
    longint half;
    longint cq;
    half = (longint'(scr) * longint'(dz_frac) * (longint'(1) << FRAC)) / (2 * longint'(zoom));
    cq = longint'(cur) << FRAC;
    if (cq - ctr > half) return cq - half;
    if (ctr - cq > half) return cq + half;
    return ctr;
  endfunction

  function automatic longint clamp_center(input longint v, input logic [SCREEN_W-1:0] scr);
    longint hi;
    hi = longint'(scr) << FRAC;
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the tracker by one frame and return the view center it reports
  function automatic center_t track_frame(input frame_t f);
    center_t r;
    logic    moved;
    logic    raw;
    if (f.func == FUNC_RECENTER) begin
      ctr_x = longint'(scr_w) << (FRAC - 1);
      ctr_y = longint'(scr_h) << (FRAC - 1);
    end else begin
      moved = !seen || f.cx != last_cx || f.cy != last_cy;
      raw = f.dx != '0 || f.dy != '0;
      if (moved) begin
        locked = 1'b0;
        frozen_ticks = '0;
        if (f.zoom > ZOOM_ONE && dz_frac != '0) begin
          ctr_x = band_follow(ctr_x, f.cx, scr_w, f.zoom);
          ctr_y = band_follow(ctr_y, f.cy, scr_h, f.zoom);
        end else begin
          ctr_x = longint'(f.cx) << FRAC;
          ctr_y = longint'(f.cy) << FRAC;
        end
      end else if (raw) begin
        // Count frozen ticks until the lock engages, then pan
        if (!locked) begin
          if (frozen_ticks < CNT_MAX) frozen_ticks = frozen_ticks + 1'b1;
          if (frozen_ticks >= LOCK_TICKS) locked = 1'b1;
        end
        if (locked) begin
          ctr_x = ctr_x + longint'($signed(f.dx)) * longint'(gain);
          ctr_y = ctr_y + longint'($signed(f.dy)) * longint'(gain);
        end
      end else begin
        frozen_ticks = '0;
      end
      ctr_x = clamp_center(ctr_x, scr_w);
      ctr_y = clamp_center(ctr_y, scr_h);
      last_cx = f.cx;
      last_cy = f.cy;
      seen = 1'b1;
    end
    r.x = CENTER_W'(ctr_x);
    r.y = CENTER_W'(ctr_y);
    r.lock = locked;
    return r;
  endfunction

  // Directed table rows
  function automatic plan_row_t frame_row(input logic fn, input int cx, input int cy,
                                          input int dx, input int dy, input int zoom);
    plan_row_t row;
    row.is_reg = 1'b0;
    row.idx = CFG_SCREEN_WIDTH;
    row.val = '0;
    row.f.func = fn;
    row.f.cx = SCREEN_W'(cx);
    row.f.cy = SCREEN_W'(cy);
    row.f.dx = DELTA_W'(dx);
    row.f.dy = DELTA_W'(dy);
    row.f.zoom = ZOOM_W'(zoom);
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic fn, input int cx, input int cy,
                                            input int dx, input int dy, input int zoom,
                                            input int ex, input int ey, input bit el);
    plan_row_t row;
    row = frame_row(fn, cx, cy, dx, dy, zoom);
    row.typed = 1'b1;
    row.want.x = CENTER_W'(ex);
    row.want.y = CENTER_W'(ey);
    row.want.lock = el;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input cfg_index_t idx, input int val);
    plan_row_t row;
    row = frame_row(FUNC_UPDATE, 0, 0, 0, 0, 0);
    row.is_reg = 1'b1;
    row.idx = idx;
    row.val = CFG_W'(val);
    return row;
  endfunction

  // Random stimulus pieces
  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return DELTA_W'($urandom_range(0, 128)) - DELTA_W'(64);
      2: return DELTA_W'($urandom);
      3: return $urandom_range(0, 1) ? {1'b1, {(DELTA_W-1){1'b0}}}
                                     : {1'b0, {(DELTA_W-1){1'b1}}};
      default: return DELTA_W'($urandom_range(0, 8)) - DELTA_W'(4);
    endcase
  endfunction

  function automatic logic [SCREEN_W-1:0] pick_cursor(input logic [SCREEN_W-1:0] last,
                                                      input logic [SCREEN_W-1:0] scr);
    case ($urandom_range(0, 3))
      0: return SCREEN_W'($urandom);
      1: return SCREEN_W'($urandom_range(0, scr));
      2: return last + SCREEN_W'($urandom_range(0, 64)) - SCREEN_W'(32);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [SCREEN_W-1:0] pick_screen();
    case ($urandom_range(0, 3))
      0: return SCREEN_W'(1);
      1: return '1;
      2: return SCREEN_W'($urandom_range(1, 8191));
      default: return SCREEN_W'($urandom_range(640, 3840));
    endcase
  endfunction

  // Build a frame: moves followed by runs of frozen ticks, some recenters and noise
  function automatic frame_t make_frame();
    frame_t f;
    int     pick;
    f.func = FUNC_UPDATE;
    f.cx = SCREEN_W'($urandom);
    f.cy = SCREEN_W'($urandom);
    f.dx = pick_delta();
    f.dy = pick_delta();
    case ($urandom_range(0, 3))
      0: f.zoom = ZOOM_W'($urandom);
      1: f.zoom = ZOOM_ONE + ZOOM_W'($urandom_range(0, 8)) - ZOOM_W'(4);
      2: f.zoom = ZOOM_W'($urandom_range(257, 2048));
      default: f.zoom = $urandom_range(0, 1) ? '1 : '0;
    endcase
    pick = $urandom_range(0, 99);
    if (run_left > 0) begin
      run_left--;
      f.cx = last_cx;
      f.cy = last_cy;
    end else if (pick < 8) begin
      f.func = FUNC_RECENTER;
    end else if (pick < 50) begin
      f.cx = pick_cursor(last_cx, scr_w);
      f.cy = pick_cursor(last_cy, scr_h);
      run_left = $urandom_range(0, 6);
    end else if (pick < 80) begin
      f.cx = last_cx;
      f.cy = last_cy;
    end else if (pick < 92) begin
      f.cx = last_cx;
      f.cy = last_cy;
      f.dx = '0;
      f.dy = '0;
    end
    return f;
  endfunction

  // Drop valid and wait until every expected result has come back
  task automatic settle();
    item_if.valid = 1'b0;
    while (center_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    settle();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_SCREEN_WIDTH:  scr_w = val[SCREEN_W-1:0];
      CFG_SCREEN_HEIGHT: scr_h = val[SCREEN_W-1:0];
      CFG_PAN_SENS:      gain = val[SENS_W-1:0];
      CFG_DEADZONE:      dz_frac = val[DZ_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one frame in bursts with random gaps; predict it on acceptance
  task automatic offer(input frame_t f, input bit typed, input center_t want);
    int      gap;
    center_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        item_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    item_if.func = f.func;
    item_if.cursor_x = f.cx;
    item_if.cursor_y = f.cy;
    item_if.raw_dx = f.dx;
    item_if.raw_dy = f.dy;
    item_if.zoom_level = f.zoom;
    item_if.valid = 1'b1;
    do @(posedge clk); while (!item_if.ready);
    predicted = track_frame(f);
    center_q.push_back(typed ? want : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // Receiver: stall patterns of its own, plus a long hold on request
  initial begin
    int seg_left;
    int seg_mode;
    seg_left = 0;
    seg_mode = 0;
    result_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        result_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 64);
      end
      case (seg_mode)
        0: result_if.ready = 1'b1;
        1: result_if.ready = $urandom_range(0, 1) != 0;
        2: result_if.ready = $urandom_range(0, 3) == 0;
        default: result_if.ready = $urandom_range(0, 9) != 0;
      endcase
      seg_left--;
      @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    center_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (center_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d lock=%0b", $time,
                 result_if.center_x, result_if.center_y, result_if.lock_active);
        error_count++;
      end else begin
        want = center_q.pop_front();
        if (result_if.center_x !== want.x) begin
          $display("%0t: center_x expected %0d, got %0d", $time, want.x, result_if.center_x);
          error_count++;
        end
        if (result_if.center_y !== want.y) begin
          $display("%0t: center_y expected %0d, got %0d", $time, want.y, result_if.center_y);
          error_count++;
        end
        if (result_if.lock_active !== want.lock) begin
          $display("%0t: lock_active expected %0b, got %0b", $time, want.lock,
                   result_if.lock_active);
          error_count++;
        end
      end
    end
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    int        sent;
    int        phase;
    int        span;
    item_if.valid = 1'b0;
    item_if.func = FUNC_UPDATE;
    item_if.cursor_x = '0;
    item_if.cursor_y = '0;
    item_if.raw_dx = '0;
    item_if.raw_dy = '0;
    item_if.zoom_level = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset view, first update, clamps, lock engage and pan extremes,
    // deadzone band edges, screen size extremes
    plan = '{
      checked_row(FUNC_RECENTER, 0, 0, 0, 0, 256, 245760, 138240, 1'b0),
      checked_row(FUNC_UPDATE, 0, 0, 0, 0, 256, 0, 0, 1'b0),
      checked_row(FUNC_UPDATE, 8191, 8191, 0, 0, 0, 491520, 276480, 1'b0),
      checked_row(FUNC_UPDATE, 8191, 8191, 1, 0, 0, 491520, 276480, 1'b0),
      checked_row(FUNC_UPDATE, 8191, 8191, -1, 1, 0, 491520, 276480, 1'b0),
      checked_row(FUNC_UPDATE, 8191, 8191, -32768, 32767, 0, 0, 276480, 1'b1),
      checked_row(FUNC_UPDATE, 8191, 8191, 0, 0, 0, 0, 276480, 1'b1),
      checked_row(FUNC_UPDATE, 8191, 8191, 32767, -32768, 0, 491520, 0, 1'b1),
      checked_row(FUNC_RECENTER, 8191, 8191, 0, 0, 0, 245760, 138240, 1'b1),
      checked_row(FUNC_UPDATE, 1000, 500, 0, 0, 65535, 256000, 128000, 1'b0),
      reg_row(CFG_DEADZONE, 256),
      frame_row(FUNC_UPDATE, 1100, 500, 0, 0, 512),
      frame_row(FUNC_UPDATE, 8191, 0, 0, 0, 257),
      frame_row(FUNC_UPDATE, 8191, 0, 5, -5, 257),
      frame_row(FUNC_UPDATE, 0, 8191, 0, 0, 65535),
      reg_row(CFG_DEADZONE, 1),
      frame_row(FUNC_UPDATE, 960, 540, 0, 0, 257),
      checked_row(FUNC_UPDATE, 961, 540, 0, 0, 256, 246016, 138240, 1'b0),
      reg_row(CFG_SCREEN_WIDTH, 1),
      reg_row(CFG_SCREEN_HEIGHT, 8191),
      reg_row(CFG_PAN_SENS, 4095),
      checked_row(FUNC_UPDATE, 5, 5, 0, 0, 256, 256, 1280, 1'b0),
      frame_row(FUNC_UPDATE, 5, 5, 1, -1, 256),
      frame_row(FUNC_UPDATE, 5, 5, 1, -1, 256),
      frame_row(FUNC_UPDATE, 5, 5, 1, -1, 256),
      checked_row(FUNC_RECENTER, 5, 5, 0, 0, 256, 128, 1048448, 1'b1),
      reg_row(CFG_PAN_SENS, 0),
      reg_row(CFG_SCREEN_WIDTH, 8191),
      reg_row(CFG_SCREEN_HEIGHT, 1),
      frame_row(FUNC_UPDATE, 5, 5, 100, 100, 256),
      frame_row(FUNC_UPDATE, 8191, 8191, 0, 0, 65535)
    };
    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].val);
      else offer(plan[i].f, plan[i].typed, plan[i].want);
    end

    // Random phases, each under a fresh register setting
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_reg(CFG_SCREEN_WIDTH, pick_screen());
      write_reg(CFG_SCREEN_HEIGHT, pick_screen());
      case ($urandom_range(0, 3))
        0: write_reg(CFG_PAN_SENS, '0);
        1: write_reg(CFG_PAN_SENS, CFG_W'(4095));
        2: write_reg(CFG_PAN_SENS, CFG_W'(256));
        default: write_reg(CFG_PAN_SENS, CFG_W'($urandom_range(0, 4095)));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CFG_DEADZONE, '0);
        1: write_reg(CFG_DEADZONE, CFG_W'(1));
        2: write_reg(CFG_DEADZONE, CFG_W'(256));
        default: write_reg(CFG_DEADZONE, CFG_W'($urandom_range(1, 256)));
      endcase
      span = $urandom_range(30, 90);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      // Hold the receiver off while the sender streams, so the block backs up
      if (phase == 1 || phase == 5) begin
        hold_req = 1'b1;
        gap_max = 0;
        burst_left = span;
      end
      for (int k = 0; k < span; k++) begin
        if (phase == 2 && k == span / 2) settle();
        offer(make_frame(), 1'b0, '0);
      end
      sent += span;
      phase++;
    end

    settle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/zvct_pkg.sv
rtl/core/zvct_if.sv
rtl/core/zvct_div.sv
rtl/core/zvct_ctrl.sv
rtl/core/zvct_dpath.sv
rtl/core/zoom_view_center_tracker_top.sv
sim/tb_zoom_view_center_tracker_top.sv
